@@ design/ulx_pkg.sv @@
package ulx_pkg;

  // Default widths
  localparam int SAMPLE_WIDTH_DEF   = 16;
  localparam int COEF_FRAC_BITS_DEF = 15;

  // Most fine samples one coarse sample can cause
  localparam int MAX_FINE = 4;
  localparam int SLOT_W   = $clog2(MAX_FINE);

  // Which weighted sum a fine sample is
  typedef enum logic [2:0] {
    K_EDGE_LEFT,   // 1.25*p - 0.25*s
    K_NEAR_PREV,   // 0.75*p + 0.25*s
    K_NEAR_CUR,    // 0.25*p + 0.75*s
    K_THIRD,       // 2/3*p + 1/3*s
    K_PASS,        // s
    K_EDGE_RIGHT   // 1.25*s - 0.25*p
  } kind_t;

  // One fine sample request from the job register to the output stage
  typedef struct packed {
    logic  valid;
    kind_t kind;
    logic  final_out;
  } issue_t;

endpackage

@@ design/ulx_mix.sv @@
module ulx_mix #(
  parameter int SAMPLE_WIDTH   = ulx_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = ulx_pkg::COEF_FRAC_BITS_DEF
) (
  input  ulx_pkg::kind_t                  kind,
  input  logic signed [SAMPLE_WIDTH-1:0]  prev_val,
  input  logic signed [SAMPLE_WIDTH-1:0]  cur_val,
  output logic signed [SAMPLE_WIDTH-1:0]  mix_val
);

  localparam int CW   = COEF_FRAC_BITS + 2;
  localparam int PW   = SAMPLE_WIDTH + CW;
  localparam int SUMW = PW + 1;
  localparam int RW   = SUMW - COEF_FRAC_BITS;

  localparam longint ONE_L = longint'(1) << COEF_FRAC_BITS;
  localparam longint C125_L = ONE_L + (ONE_L >> 2);
  localparam longint C025_L = ONE_L >> 2;
  localparam longint C075_L = (3 * ONE_L) >> 2;
  localparam longint C23_L  = (2 * ONE_L + 1) / 3;
  localparam longint C13_L  = (ONE_L + 1) / 3;

  localparam logic signed [CW-1:0] C_ONE  = CW'(ONE_L);
  localparam logic signed [CW-1:0] C_125  = CW'(C125_L);
  localparam logic signed [CW-1:0] C_025  = CW'(C025_L);
  localparam logic signed [CW-1:0] C_N025 = CW'(-C025_L);
  localparam logic signed [CW-1:0] C_075  = CW'(C075_L);
  localparam logic signed [CW-1:0] C_23   = CW'(C23_L);
  localparam logic signed [CW-1:0] C_13   = CW'(C13_L);

  localparam logic signed [SUMW-1:0] HALF = SUMW'(ONE_L >> 1);
  localparam logic signed [RW-1:0] S_MAX = RW'((longint'(1) << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [RW-1:0] S_MIN = RW'(-(longint'(1) << (SAMPLE_WIDTH - 1)));

  logic signed [SAMPLE_WIDTH-1:0] op_a;
  logic signed [SAMPLE_WIDTH-1:0] op_b;
  logic signed [CW-1:0]           coef_a;
  logic signed [CW-1:0]           coef_b;
  logic signed [PW-1:0]           prod_a;
  logic signed [PW-1:0]           prod_b;
  logic signed [SUMW-1:0]         sum;
  logic signed [RW-1:0]           rounded;

  // Pick operands and weights
  always_comb begin
    op_a   = prev_val;
    op_b   = cur_val;
    coef_a = C_075;
    coef_b = C_025;
    case (kind)
      ulx_pkg::K_EDGE_LEFT: begin
        coef_a = C_125;
        coef_b = C_N025;
      end
      ulx_pkg::K_NEAR_PREV: begin
        coef_a = C_075;
        coef_b = C_025;
      end
      ulx_pkg::K_NEAR_CUR: begin
        coef_a = C_025;
        coef_b = C_075;
      end
      ulx_pkg::K_THIRD: begin
        coef_a = C_23;
        coef_b = C_13;
      end
      ulx_pkg::K_EDGE_RIGHT: begin
        op_a   = cur_val;
        op_b   = prev_val;
        coef_a = C_125;
        coef_b = C_N025;
      end
      default: begin
        // pass the current sample through at unit weight
        op_a   = cur_val;
        op_b   = '0;
        coef_a = C_ONE;
        coef_b = '0;
      end
    endcase
  end

  // Weighted sum, round half up, floor shift
  assign prod_a  = PW'(op_a) * PW'(coef_a);
  assign prod_b  = PW'(op_b) * PW'(coef_b);
  assign sum     = SUMW'(prod_a) + SUMW'(prod_b) + HALF;
  assign rounded = $signed(sum[SUMW-1:COEF_FRAC_BITS]);

  // Saturate to the sample range
  always_comb begin
    if (rounded > S_MAX) begin
      mix_val = S_MAX[SAMPLE_WIDTH-1:0];
    end else if (rounded < S_MIN) begin
      mix_val = S_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      mix_val = rounded[SAMPLE_WIDTH-1:0];
    end
  end

endmodule

@@ design/ulx_job.sv @@
module ulx_job #(
  parameter int SAMPLE_WIDTH = ulx_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [1:0]                     seen,
  input  logic                           last_in,
  input  logic                           odd_len,
  input  logic signed [SAMPLE_WIDTH-1:0] prev_in,
  input  logic signed [SAMPLE_WIDTH-1:0] cur_in,
  input  logic                           take,
  output logic                           free,
  output ulx_pkg::issue_t                issue,
  output logic signed [SAMPLE_WIDTH-1:0] prev_val,
  output logic signed [SAMPLE_WIDTH-1:0] cur_val
);

  localparam int SW = ulx_pkg::SLOT_W;

  logic                   busy;
  logic [SW-1:0]          slot;
  logic [SW-1:0]          last_slot;
  logic                   item_last;
  ulx_pkg::kind_t         kinds [ulx_pkg::MAX_FINE];

  ulx_pkg::kind_t         kinds_next [ulx_pkg::MAX_FINE];
  logic [SW-1:0]          last_slot_next;
  logic                   has_work;
  logic                   at_end;

  // Build the list of fine samples this item causes
  always_comb begin
    for (int i = 0; i < ulx_pkg::MAX_FINE; i++) begin
      kinds_next[i] = ulx_pkg::K_PASS;
    end
    last_slot_next = '0;
    has_work       = 1'b1;
    if (seen == 2'd0) begin
      // first sample: stored, or emitted alone for a one-sample run
      has_work = last_in;
    end else if (seen == 2'd1) begin
      kinds_next[0] = ulx_pkg::K_EDGE_LEFT;
      if (last_in && odd_len) begin
        kinds_next[1]  = ulx_pkg::K_THIRD;
        kinds_next[2]  = ulx_pkg::K_PASS;
        last_slot_next = SW'(2);
      end else begin
        kinds_next[1]  = ulx_pkg::K_NEAR_PREV;
        kinds_next[2]  = ulx_pkg::K_NEAR_CUR;
        kinds_next[3]  = ulx_pkg::K_EDGE_RIGHT;
        last_slot_next = last_in ? SW'(3) : SW'(2);
      end
    end else begin
      if (last_in && odd_len) begin
        kinds_next[0]  = ulx_pkg::K_THIRD;
        kinds_next[1]  = ulx_pkg::K_PASS;
        last_slot_next = SW'(1);
      end else begin
        kinds_next[0]  = ulx_pkg::K_NEAR_PREV;
        kinds_next[1]  = ulx_pkg::K_NEAR_CUR;
        kinds_next[2]  = ulx_pkg::K_EDGE_RIGHT;
        last_slot_next = last_in ? SW'(2) : SW'(1);
      end
    end
  end

  assign at_end = (slot == last_slot);
  assign free   = !busy || (take && at_end);

  // Hold the item and step through its fine samples
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      slot <= '0;
    end else if (accept && has_work) begin
      busy <= 1'b1;
      slot <= '0;
    end else if (busy && take) begin
      if (at_end) begin
        busy <= 1'b0;
      end else begin
        slot <= slot + SW'(1);
      end
    end
  end

  // Load the payload of a new item
  always_ff @(posedge clk) begin
    if (accept && has_work) begin
      kinds     <= kinds_next;
      last_slot <= last_slot_next;
      item_last <= last_in;
      prev_val  <= prev_in;
      cur_val   <= cur_in;
    end
  end

  assign issue.valid     = busy;
  assign issue.kind      = kinds[slot];
  assign issue.final_out = item_last && at_end;

  // The slot never runs past the end of the list
  assert property (@(posedge clk) disable iff (rst)
    busy && take && !at_end && !(accept && has_work) |=> busy)
    else $error("job dropped before its last fine sample");

  assert property (@(posedge clk) disable iff (rst)
    busy |-> slot <= last_slot)
    else $error("slot beyond end of list");

  assert property (@(posedge clk) disable iff (rst)
    accept |-> free)
    else $error("item accepted while job still pending");

endmodule

@@ design/linear_upsample_2x_edge_extrap.sv @@
// Doubles a run of coarse samples by linear interpolation (3/4, 1/4 weights) with
// extrapolated edges. The first sample of a run is stored and emits nothing; the
// second emits the left-edge value and two interpolated values; each later sample
// emits two; the last sample adds the right-edge value, or, when cfg_data set the
// odd-length mode, ends with a 2/3-1/3 value and the sample itself. A run of one
// sample emits that sample. last_of_run flags the final fine value of a run.
// Flow: an item that causes k fine values holds the job register until the output
// register takes them, one fine value per cycle unless out_ready stalls it; an item
// that causes none is taken without holding it. The next item is taken in the cycle
// the job issues its final value. An input passes the job register, then the output
// register, on its way out. Write cfg_data only while the block is idle.
module linear_upsample_2x_edge_extrap #(
  parameter int SAMPLE_WIDTH   = ulx_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = ulx_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           last_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] fine_value,
  output logic                           last_of_run
);

  logic                           odd_output_length;
  logic signed [SAMPLE_WIDTH-1:0] previous_sample;
  logic [1:0]                     samples_seen;

  logic                           accept;
  logic                           take;
  logic                           job_free;
  ulx_pkg::issue_t                job_issue;
  logic signed [SAMPLE_WIDTH-1:0] job_prev;
  logic signed [SAMPLE_WIDTH-1:0] job_cur;
  logic signed [SAMPLE_WIDTH-1:0] mix_val;

  assign cfg_ready = 1'b1;
  assign in_ready  = job_free;
  assign accept    = in_valid && in_ready;
  assign take      = !out_valid || out_ready;

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      odd_output_length <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      odd_output_length <= cfg_data;
    end
  end

  // Run state: previous sample and saturating count
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= '0;
      samples_seen    <= 2'd0;
    end else if (accept) begin
      if (last_sample) begin
        previous_sample <= '0;
        samples_seen    <= 2'd0;
      end else begin
        previous_sample <= sample;
        samples_seen    <= (samples_seen == 2'd0) ? 2'd1 : 2'd2;
      end
    end
  end

  ulx_job #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_job (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .seen     (samples_seen),
    .last_in  (last_sample),
    .odd_len  (odd_output_length),
    .prev_in  (previous_sample),
    .cur_in   (sample),
    .take     (take),
    .free     (job_free),
    .issue    (job_issue),
    .prev_val (job_prev),
    .cur_val  (job_cur)
  );

  ulx_mix #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_mix (
    .kind     (job_issue.kind),
    .prev_val (job_prev),
    .cur_val  (job_cur),
    .mix_val  (mix_val)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= job_issue.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && job_issue.valid) begin
      fine_value  <= mix_val;
      last_of_run <= job_issue.final_out;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    accept && last_sample |=> samples_seen == 2'd0 && previous_sample == '0)
    else $error("run state not cleared after last sample");

  assert property (@(posedge clk) disable iff (rst)
    samples_seen != 2'd3)
    else $error("sample count beyond saturation");

  assert property (@(posedge clk) disable iff (rst)
    accept && !last_sample && samples_seen != 2'd0 |=> job_issue.valid)
    else $error("interior sample produced no fine values");

  assert property (@(posedge clk) disable iff (rst)
    accept && samples_seen == 2'd0 && !last_sample && !job_issue.valid |=> !job_issue.valid)
    else $error("first sample of a run started a job");

endmodule
